// ===== rtl/core/gll_pkg.sv =====
package gll_pkg;

    // Default widths for the top-level parameters.
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF    = 32;

    localparam int KIND_WIDTH = 4;

    // Token kinds as they leave on tuser.
    localparam logic [KIND_WIDTH-1:0] TK_EOF       = 4'd0;
    localparam logic [KIND_WIDTH-1:0] TK_NUMBER    = 4'd1;
    localparam logic [KIND_WIDTH-1:0] TK_H         = 4'd2;
    localparam logic [KIND_WIDTH-1:0] TK_X         = 4'd3;
    localparam logic [KIND_WIDTH-1:0] TK_Z         = 4'd4;
    localparam logic [KIND_WIDTH-1:0] TK_CNOT      = 4'd5;
    localparam logic [KIND_WIDTH-1:0] TK_QUBIT     = 4'd6;
    localparam logic [KIND_WIDTH-1:0] TK_MEASURE   = 4'd7;
    localparam logic [KIND_WIDTH-1:0] TK_LPAREN    = 4'd8;
    localparam logic [KIND_WIDTH-1:0] TK_RPAREN    = 4'd9;
    localparam logic [KIND_WIDTH-1:0] TK_COMMA     = 4'd10;
    localparam logic [KIND_WIDTH-1:0] TK_BAD_IDENT = 4'd11;
    localparam logic [KIND_WIDTH-1:0] TK_BAD_CHAR  = 4'd12;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_UPPER_H    = 8'h48;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UPPER_C    = 8'h43;
    localparam logic [7:0] CH_LOWER_Q    = 8'h71;
    localparam logic [7:0] CH_LOWER_M    = 8'h6D;

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDERSCORE);
    endfunction

    // Keyword spellings, one character per index.
    function automatic logic [7:0] cnot_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h43;  // C
            2'd1:    ch = 8'h4E;  // N
            2'd2:    ch = 8'h4F;  // O
            default: ch = 8'h54;  // T
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] ubit_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h75;  // u
            2'd1:    ch = 8'h62;  // b
            2'd2:    ch = 8'h69;  // i
            default: ch = 8'h74;  // t
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] easure_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h65;  // e
            3'd1:    ch = 8'h61;  // a
            3'd2:    ch = 8'h73;  // s
            3'd3:    ch = 8'h75;  // u
            3'd4:    ch = 8'h72;  // r
            3'd5:    ch = 8'h65;  // e
            default: ch = 8'h00;  // past the end of the word
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/gate_language_lexer.sv =====
// Channel   | Dir | Beat contents (lowest bits first)
// ----------+-----+----------------------------------------------------------------
// s_axis    | in  | tdata: source_byte; tlast: end_of_source
// m_axis    | out | tuser: token_kind; tdata: lexeme_start, lexeme_length,
//           |     | line_number, number_value; tlast: last_of_run
//
// One source byte can be taken every cycle while its tokens fit in the queue. A byte
// is held in the input register, is classified and folded into the scan state, and
// its tokens (zero, one or two) enter a two-entry result queue whose head drives
// m_axis; the input register and the queue lie between a byte's transfer and its
// tokens on m_axis. A byte with two tokens is taken only when both fit.
// Reset empties both registers and queue and scans from byte 0, line 1; a stall
// on m_axis fills the queue and drops s_axis_tready until the byte's tokens fit.
module gate_language_lexer
    import gll_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // source_byte
    input  logic                   s_axis_tlast,   // end_of_source

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // lexeme_start, lexeme_length, line_number, number_value, zero fill to bytes
    output logic [((3*POSITION_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic [KIND_WIDTH-1:0]  m_axis_tuser,   // token_kind
    output logic                   m_axis_tlast    // last_of_run
);

    localparam int TDATA_WIDTH = ((3*POSITION_WIDTH+VALUE_WIDTH+7)/8)*8;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] POS_FOUR = POSITION_WIDTH'(4);
    localparam logic [POSITION_WIDTH-1:0] POS_FIVE = POSITION_WIDTH'(5);
    localparam logic [POSITION_WIDTH-1:0] POS_SEVEN = POSITION_WIDTH'(7);

    // A number saturates once acc*10 + digit would pass the largest value.
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX       = '1;
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX_DIV10 = VAL_MAX / 10;
    localparam logic [3:0]             VAL_MAX_MOD10 = 4'(VAL_MAX % 10);

    // Scan modes.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_NUMBER  = 2'd1;
    localparam logic [1:0] MODE_IDENT   = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]     kind;
        logic [POSITION_WIDTH-1:0] start;
        logic [POSITION_WIDTH-1:0] length;
        logic [POSITION_WIDTH-1:0] line;
        logic [VALUE_WIDTH-1:0]    value;
        logic                      last;
    } tok_t;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // Scan state.
    logic [1:0]                mode_reg, mode_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic [POSITION_WIDTH-1:0] count_reg, count_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [7:0]                first_reg, first_next;
    logic [2:0]                kw_reg, kw_next;
    logic [VALUE_WIDTH-1:0]    acc_reg, acc_next;

    // Result queue: head drives m_axis, tail waits behind it.
    logic [1:0] qcount_reg, qcount_next;
    tok_t       head_reg, head_next;
    tok_t       tail_reg, tail_next;

    // Per-byte results.
    tok_t       res0, res1;
    logic [1:0] nres;

    logic       pop;
    logic [1:0] left;
    logic       consume;

    // Scan logic for the byte in the input register.
    always_comb
    begin
        logic [7:0]                c;
        logic                      digit;
        logic                      alpha;
        logic                      stay;
        logic                      flush_has;
        logic                      second_has;
        tok_t                      flush_tok;
        tok_t                      second_tok;
        logic [KIND_WIDTH-1:0]     ident_kind;
        logic [KIND_WIDTH-1:0]     punct_kind;
        logic [POSITION_WIDTH-1:0] pos_inc;
        logic [POSITION_WIDTH-1:0] count_inc;
        logic [POSITION_WIDTH-1:0] line_inc;
        logic [POSITION_WIDTH-1:0] cnt_m1;
        logic [3:0]                d;
        logic                      kw0_keep;
        logic                      kw1_keep;
        logic                      kw2_keep;

        c         = in_byte_reg;
        digit     = is_decimal(c);
        alpha     = is_letter(c);
        d         = 4'(c - CH_ZERO);
        pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_ONE;
        count_inc = (count_reg == POS_MAX) ? count_reg : count_reg + POS_ONE;
        line_inc  = (line_reg == POS_MAX) ? line_reg : line_reg + POS_ONE;
        cnt_m1    = count_reg - POS_ONE;

        // Keyword prefixes are checked against the character's place in the word.
        kw0_keep = !((count_reg < POS_FOUR) && (c != cnot_char(count_reg[1:0])));
        kw1_keep = (count_reg >= POS_ONE) && (count_reg < POS_FIVE)
                && (c == ubit_char(cnt_m1[1:0]));
        kw2_keep = (count_reg >= POS_ONE) && (count_reg < POS_SEVEN)
                && (c == easure_char(cnt_m1[2:0]));

        unique case (first_reg)
            CH_UPPER_H: ident_kind = TK_H;
            CH_UPPER_X: ident_kind = TK_X;
            CH_UPPER_Z: ident_kind = TK_Z;
            CH_UPPER_C: ident_kind = (kw_reg[0] && (count_reg >= POS_FOUR))
                                     ? TK_CNOT : TK_BAD_IDENT;
            CH_LOWER_Q: ident_kind = (kw_reg[1] && (count_reg == POS_FIVE))
                                     ? TK_QUBIT : TK_BAD_IDENT;
            CH_LOWER_M: ident_kind = (kw_reg[2] && (count_reg == POS_SEVEN))
                                     ? TK_MEASURE : TK_BAD_IDENT;
            default:    ident_kind = TK_BAD_IDENT;
        endcase

        unique case (c)
            CH_LPAREN: punct_kind = TK_LPAREN;
            CH_RPAREN: punct_kind = TK_RPAREN;
            CH_COMMA:  punct_kind = TK_COMMA;
            default:   punct_kind = TK_BAD_CHAR;
        endcase

        // The pending number or identifier, should this byte end it.
        flush_tok.kind   = (mode_reg == MODE_NUMBER) ? TK_NUMBER : ident_kind;
        flush_tok.start  = start_reg;
        flush_tok.length = count_reg;
        flush_tok.line   = line_reg;
        flush_tok.value  = (mode_reg == MODE_NUMBER) ? acc_reg : '0;
        flush_tok.last   = 1'b0;

        second_tok.kind   = punct_kind;
        second_tok.start  = pos_reg;
        second_tok.length = POS_ONE;
        second_tok.line   = line_reg;
        second_tok.value  = '0;
        second_tok.last   = 1'b1;

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        count_next = count_reg;
        line_next  = line_reg;
        first_next = first_reg;
        kw_next    = kw_reg;
        acc_next   = acc_reg;
        second_has = 1'b0;

        stay = ((mode_reg == MODE_NUMBER) && digit)
            || ((mode_reg == MODE_IDENT) && (alpha || digit))
            || (mode_reg == MODE_COMMENT);
        flush_has = ((mode_reg == MODE_NUMBER) || (mode_reg == MODE_IDENT))
                 && (in_end_reg || !stay);

        if (in_end_reg)
        begin
            // End of text: flush, emit EOF at the current position, start over.
            second_has        = 1'b1;
            second_tok.kind   = TK_EOF;
            second_tok.length = '0;
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
            line_next  = POS_ONE;
            first_next = '0;
            kw_next    = '0;
            acc_next   = '0;
        end
        else if (stay)
        begin
            pos_next = pos_inc;
            if (mode_reg == MODE_NUMBER)
            begin
                count_next = count_inc;
                if ((acc_reg > VAL_MAX_DIV10)
                    || ((acc_reg == VAL_MAX_DIV10) && (d > VAL_MAX_MOD10)))
                    acc_next = VAL_MAX;
                else
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + VALUE_WIDTH'(d);
            end
            else if (mode_reg == MODE_IDENT)
            begin
                count_next = count_inc;
                kw_next    = kw_reg & {kw2_keep, kw1_keep, kw0_keep};
            end
            else if (c == CH_NEWLINE)
            begin
                line_next = line_inc;
                mode_next = MODE_IDLE;
            end
        end
        else
        begin
            // Idle handling, after any pending token was flushed.
            mode_next = MODE_IDLE;
            pos_next  = pos_inc;
            if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR))
            begin
                mode_next = MODE_IDLE;
            end
            else if (c == CH_NEWLINE)
            begin
                line_next = line_inc;
            end
            else if (c == CH_HASH)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (digit)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                count_next = POS_ONE;
                acc_next   = VALUE_WIDTH'(d);
            end
            else if (alpha)
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                count_next = POS_ONE;
                first_next = c;
                kw_next    = {c == CH_LOWER_M, c == CH_LOWER_Q, c == CH_UPPER_C};
            end
            else
            begin
                second_has = 1'b1;
            end
        end

        // Pack the results in order; the final one carries last.
        if (flush_has)
        begin
            res0      = flush_tok;
            res0.last = !second_has;
            res1      = second_tok;
            nres      = second_has ? 2'd2 : 2'd1;
        end
        else
        begin
            res0 = second_tok;
            res1 = second_tok;
            nres = second_has ? 2'd1 : 2'd0;
        end
    end

    // Queue bookkeeping: a byte is taken only when all its results fit.
    assign pop     = (qcount_reg != 2'd0) && m_axis_tready;
    assign left    = qcount_reg - {1'b0, pop};
    assign consume = in_valid_reg && (nres <= (2'd2 - left));

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        qcount_next = left + (consume ? nres : 2'd0);
        case (left)
            2'd0:
            begin
                head_next = res0;
                tail_next = res1;
            end
            2'd1:
            begin
                head_next = pop ? tail_reg : head_reg;
                tail_next = res0;
            end
            default:
            begin
                head_next = head_reg;
                tail_next = tail_reg;
            end
        endcase
    end

    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            qcount_reg   <= 2'd0;
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
            line_reg     <= POS_ONE;
            first_reg    <= '0;
            kw_reg       <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            qcount_reg <= qcount_next;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (consume)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                count_reg <= count_next;
                line_reg  <= line_next;
                first_reg <= first_next;
                kw_reg    <= kw_next;
                acc_reg   <= acc_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_axis_tvalid = (qcount_reg != 2'd0);
    assign m_axis_tuser  = head_reg.kind;
    assign m_axis_tlast  = head_reg.last;
    assign m_axis_tdata  = TDATA_WIDTH'({head_reg.value, head_reg.line,
                                         head_reg.length, head_reg.start});

endmodule

// ===== tb/sv/token_stream_monitor.sv =====
// Watches both stream channels of the lexer. Every source byte taken on
// s_axis is run through a scanner of our own, and the tokens it yields are
// queued in order; every token leaving on m_axis is checked against the
// oldest one queued.
module token_stream_monitor
    import gll_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int DATA_WIDTH     = ((3*POSITION_WIDTH+VALUE_WIDTH+7)/8)*8
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // source_byte
    input  logic                  s_axis_tlast,   // end_of_source

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // lexeme_start, lexeme_length, line_number, number_value, zero fill
    input  logic [DATA_WIDTH-1:0] m_axis_tdata,
    input  logic [KIND_WIDTH-1:0] m_axis_tuser,   // token_kind
    input  logic                  m_axis_tlast,   // last_of_run

    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_COMMENT} scan_mode_t;
    typedef logic [POSITION_WIDTH-1:0] pos_t;
    typedef logic [VALUE_WIDTH-1:0]    val_t;

    typedef struct {
        logic [KIND_WIDTH-1:0] kind;
        pos_t                  start;
        pos_t                  length;
        pos_t                  line;
        val_t                  value;
        logic                  last;
    } token_t;

    localparam pos_t        POS_MAX       = '1;
    localparam pos_t        POS_ONE       = pos_t'(1);
    localparam val_t        VAL_MAX       = '1;
    localparam logic [31:0] CNOT_SPELL    = "CNOT";
    localparam logic [39:0] QUBIT_SPELL   = "qubit";
    localparam logic [55:0] MEASURE_SPELL = "measure";

    scan_mode_t  mode;
    pos_t        byte_pos;
    pos_t        run_start;
    pos_t        run_length;
    pos_t        line_no;
    logic [7:0]  lead_char;
    logic [2:0]  keyword_hits;   // bit 0 CNOT, bit 1 qubit, bit 2 measure
    val_t        run_value;

    token_t      awaited_tokens[$];
    token_t      step_tokens[$];

    function automatic pos_t bump(input pos_t v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDERSCORE};
    endfunction

    function automatic void restart_scan();
        mode         = SCAN_IDLE;
        byte_pos     = '0;
        run_start    = '0;
        run_length   = '0;
        line_no      = POS_ONE;
        lead_char    = '0;
        keyword_hits = '0;
        run_value    = '0;
    endfunction

    function automatic void emit(input logic [KIND_WIDTH-1:0] kind, input pos_t start,
                                 input pos_t length, input val_t value);
        token_t tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = length;
        tok.line   = line_no;
        tok.value  = value;
        tok.last   = 1'b0;
        step_tokens.push_back(tok);
    endfunction

    function automatic logic [KIND_WIDTH-1:0] word_kind();
        case (lead_char)
            CH_UPPER_H: return TK_H;
            CH_UPPER_X: return TK_X;
            CH_UPPER_Z: return TK_Z;
            // CNOT only has to lead the word; qubit and measure must match exactly.
            CH_UPPER_C: return (keyword_hits[0] && run_length >= 4) ? TK_CNOT : TK_BAD_IDENT;
            CH_LOWER_Q: return (keyword_hits[1] && run_length == 5) ? TK_QUBIT : TK_BAD_IDENT;
            CH_LOWER_M: return (keyword_hits[2] && run_length == 7) ? TK_MEASURE : TK_BAD_IDENT;
            default:    return TK_BAD_IDENT;
        endcase
    endfunction

    function automatic void close_run();
        if (mode == SCAN_NUMBER)
            emit(TK_NUMBER, run_start, run_length, run_value);
        else if (mode == SCAN_WORD)
            emit(word_kind(), run_start, run_length, '0);
        if (mode != SCAN_COMMENT)
            mode = SCAN_IDLE;
    endfunction

    // idx is the number of characters already in the word.
    function automatic void match_keywords(input logic [7:0] c, input pos_t idx);
        int i;
        i = (idx > 8) ? 8 : int'(idx);
        if (i < 4 && c != CNOT_SPELL[31-8*i -: 8])
            keyword_hits[0] = 1'b0;
        if (i < 1 || i >= 5 || c != QUBIT_SPELL[39-8*i -: 8])
            keyword_hits[1] = 1'b0;
        if (i < 1 || i >= 7 || c != MEASURE_SPELL[55-8*i -: 8])
            keyword_hits[2] = 1'b0;
    endfunction

    function automatic void scan_source_byte(input logic [7:0] c, input logic eos);
        token_t tok;
        val_t   digit;
        logic   absorbed;
        step_tokens.delete();
        digit      = '0;
        digit[3:0] = c[3:0];
        if (eos) begin
            close_run();
            emit(TK_EOF, byte_pos, '0, '0);
            restart_scan();
        end
        else begin
            absorbed = 1'b0;
            case (mode)
                SCAN_NUMBER:
                    if (is_numeral(c)) begin
                        run_value  = (run_value > (VAL_MAX - digit) / 10) ? VAL_MAX
                                                                          : run_value * 10 + digit;
                        run_length = bump(run_length);
                        absorbed   = 1'b1;
                    end
                    else
                        close_run();
                SCAN_WORD:
                    if (is_numeral(c) || is_word_char(c)) begin
                        match_keywords(c, run_length);
                        run_length = bump(run_length);
                        absorbed   = 1'b1;
                    end
                    else
                        close_run();
                SCAN_COMMENT:
                begin
                    if (c == CH_NEWLINE) begin
                        line_no = bump(line_no);
                        mode    = SCAN_IDLE;
                    end
                    absorbed = 1'b1;
                end
                default:
                    absorbed = 1'b0;
            endcase

            // A byte that ended a run is also looked at on its own.
            if (!absorbed) begin
                if (c == CH_NEWLINE)
                    line_no = bump(line_no);
                else if (c == CH_HASH)
                    mode = SCAN_COMMENT;
                else if (is_numeral(c)) begin
                    mode       = SCAN_NUMBER;
                    run_start  = byte_pos;
                    run_length = POS_ONE;
                    run_value  = digit;
                end
                else if (is_word_char(c)) begin
                    mode         = SCAN_WORD;
                    run_start    = byte_pos;
                    run_length   = POS_ONE;
                    lead_char    = c;
                    keyword_hits = {c == CH_LOWER_M, c == CH_LOWER_Q, c == CH_UPPER_C};
                end
                else if (c == CH_LPAREN)
                    emit(TK_LPAREN, byte_pos, POS_ONE, '0);
                else if (c == CH_RPAREN)
                    emit(TK_RPAREN, byte_pos, POS_ONE, '0);
                else if (c == CH_COMMA)
                    emit(TK_COMMA, byte_pos, POS_ONE, '0);
                else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR))
                    emit(TK_BAD_CHAR, byte_pos, POS_ONE, '0);
            end
            byte_pos = bump(byte_pos);
        end

        if (step_tokens.size() > 0) begin
            tok      = step_tokens.pop_back();
            tok.last = 1'b1;
            step_tokens.push_back(tok);
        end
        foreach (step_tokens[i])
            awaited_tokens.push_back(step_tokens[i]);
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: token %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_token();
        token_t want;
        if (awaited_tokens.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: token of kind %0d at offset %0d arrived with none expected",
                         $time, m_axis_tuser, m_axis_tdata[POSITION_WIDTH-1:0]);
            mismatches++;
        end
        else begin
            want = awaited_tokens.pop_front();
            compare_field("kind",   64'(want.kind),   64'(m_axis_tuser));
            compare_field("start",  64'(want.start),
                          64'(m_axis_tdata[0 +: POSITION_WIDTH]));
            compare_field("length", 64'(want.length),
                          64'(m_axis_tdata[POSITION_WIDTH +: POSITION_WIDTH]));
            compare_field("line",   64'(want.line),
                          64'(m_axis_tdata[2*POSITION_WIDTH +: POSITION_WIDTH]));
            compare_field("value",  64'(want.value),
                          64'(m_axis_tdata[3*POSITION_WIDTH +: VALUE_WIDTH]));
            compare_field("last",   64'(want.last),   64'(m_axis_tlast));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restart_scan();
            awaited_tokens.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                scan_source_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                compare_token();
            pending <= awaited_tokens.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Stimulus and verdict for the gate language lexer. The token checking lives
// in token_stream_monitor; this module only feeds source text, throttles the
// token channel and decides the outcome.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gll_pkg::*;

    localparam int TOKEN_DATA_WIDTH = ((3*POSITION_WIDTH_DEF+VALUE_WIDTH_DEF+7)/8)*8;

    // A run of this many cycles with no transfer on either channel means the
    // block has hung or owes tokens it will never send.
    localparam int STALL_LIMIT = 2000;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata  = '0;
    logic                        s_axis_tlast  = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [TOKEN_DATA_WIDTH-1:0] m_axis_tdata;
    logic [KIND_WIDTH-1:0]       m_axis_tuser;
    logic                        m_axis_tlast;

    int mismatches;
    int pending;
    int bytes_sent     = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 34;
    int recv_idle_pct  = 68;

    // Vocabulary for random source text. The second list holds near misses of
    // the keywords plus plain identifiers, which must come out as bad words, as
    // gates picked by their first letter, or as CNOT for a word that starts with it.
    string gate_words[6]  = '{"H", "X", "Z", "CNOT", "qubit", "measure"};
    string odd_words[16]  = '{"CNO", "Cnot", "CNOTX", "C", "qubi", "qubitt", "qbit",
                              "measur", "measures", "m", "q", "Hx1", "X_9", "Zq",
                              "_a", "foo"};

    always #1 clk = ~clk;

    gate_language_lexer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    token_stream_monitor token_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // The token consumer stalls at random with the rate of the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: any transfer on either side resets the count.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("gate_language_lexer verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one byte and returns at the edge where it is transferred. Idle
    // cycles are inserted ahead of the byte; valid is not dropped between
    // back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_blank();
        case ($urandom_range(4))
            0: ;
            1: send_byte(CH_SPACE, 1'b0);
            2: send_byte(CH_TAB, 1'b0);
            3: send_byte(CH_CR, 1'b0);
            default: send_text("  ");
        endcase
    endtask

    // Mostly short numbers; one in ten is nine to twelve digits, which can overflow 32 bits.
    task automatic send_number();
        int digits;
        digits = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(3, 1);
        repeat (digits)
            send_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    endtask

    // Seven in ten statements are well formed, such as "CNOT(3, 12)" with a
    // trailing comment now and then. The rest are a jumble of random bytes,
    // near-miss words, numbers and blanks. Text ends at random.
    task automatic send_statement();
        int pieces;
        if ($urandom_range(9) < 7) begin
            send_text(gate_words[$urandom_range(5)]);
            send_blank();
            send_byte(CH_LPAREN, 1'b0);
            send_number();
            if ($urandom_range(1)) begin
                send_byte(CH_COMMA, 1'b0);
                send_blank();
                send_number();
            end
            send_byte(CH_RPAREN, 1'b0);
            if ($urandom_range(3) == 0)
                send_text(" # note (1, 2)");
            send_byte(CH_NEWLINE, 1'b0);
        end
        else begin
            pieces = $urandom_range(8, 1);
            repeat (pieces) begin
                case ($urandom_range(3))
                    0: send_byte(8'($urandom_range(255)), 1'b0);
                    1: send_text(odd_words[$urandom_range(15)]);
                    2: send_number();
                    default: send_blank();
                endcase
            end
        end
        if ($urandom_range(24) == 0)
            send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // Holds the source side back until every predicted token has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++) begin
            // Source idles a third of the time and the sink two thirds, then
            // the reverse, then both run flat out.
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 34 : 0;

            if (phase == 0) begin
                // Every keyword, punctuation, all three blanks, a comment, a
                // number cut short by a bad word, NUL and 0xFF as bad chars, a
                // bad char right after a pending word, and end of text with a
                // junk byte.
                send_text("CNOT(qubit,measure)");
                send_byte(CH_CR, 1'b0);
                send_text("H");
                send_byte(CH_TAB, 1'b0);
                send_text("X Z#");
                send_byte(CH_NEWLINE, 1'b0);
                send_text("9_");
                send_byte(8'h00, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(8'hFF, 1'b1);
            end

            while (bytes_sent < 250 * (phase + 1))
                send_statement();

            if (phase == 2) begin
                // An overflowing number ended by a paren, then end of text
                // while nothing is pending.
                send_text("99999999999)");
                send_byte(8'h00, 1'b1);
            end

            drain_results();
        end

        // Leave room for any stray token that should not be there.
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("gate_language_lexer verification clean");
        else
            $display("gate_language_lexer verification failed");
        $finish;
    end

endmodule
